[src/dram_pkg.sv]
`timescale 1ns / 1ps

package dram_pkg;

	// Request kinds carried on the slave tuser
	localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
	localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
	localparam logic [1:0] KIND_REMOVE     = 2'd2;
	localparam logic [1:0] KIND_CLEAR      = 2'd3;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 5;
	localparam int OUT_W     = 16;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic clear;
		logic rm_start;
		logic rd_scan;
		logic cmp_init;
		logic rd_cmp;
		logic rm_end;
	} dram_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic idx_end;
	} dram_stat_t;

endpackage

[src/dram_ctrl.sv]
`timescale 1ns / 1ps

module dram_ctrl import dram_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic [1:0] kind,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dram_stat_t stat,
	output dram_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_SCAN    = 4'b0010,
		ST_COMPACT = 4'b0100,
		ST_DRAIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   take;
	logic   res_set;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// Decode state and issue datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		res_set = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (kind)
						KIND_PUSH_FRONT: begin
							cmd.push_front = 1'b1;
							res_set        = 1'b1;
						end
						KIND_PUSH_BACK: begin
							cmd.push_back = 1'b1;
							res_set       = 1'b1;
						end
						KIND_REMOVE: begin
							cmd.rm_start = 1'b1;
							state_d      = ST_SCAN;
						end
						default: begin
							cmd.clear = 1'b1;
							res_set   = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (!stat.idx_end) begin
					cmd.rd_scan = 1'b1;
				end else begin
					cmd.cmp_init = 1'b1;
					state_d      = ST_COMPACT;
				end
			end
			ST_COMPACT: begin
				if (!stat.idx_end) begin
					cmd.rd_cmp = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					cmd.rm_end = 1'b1;
					res_set    = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state and the output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_set) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/dram_dp.sv]
`timescale 1ns / 1ps

module dram_dp import dram_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [VAL_W-1:0] value,
	input  dram_cmd_t               cmd,
	output dram_stat_t              stat,
	output logic        [OUT_W-1:0] res_word
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic        [VAL_W-1:0] mem [DEPTH];

	logic        [AW-1:0]    head_q;
	logic        [CW-1:0]    fill_q;
	logic        [CW-1:0]    n_q;
	logic        [CW-1:0]    idx_q;
	logic        [CW-1:0]    kept_q;
	logic                    first_q;
	logic signed [VAL_W-1:0] best_q;
	logic signed [VAL_W-1:0] rdata_s1;
	logic                    rdv_s1;
	logic                    rdc_s1;
	logic        [CNT_W-1:0] rcnt_q;
	logic                    ovf_q;
	logic        [CNT_W-1:0] occ_q;

	logic                    full;
	logic        [AW-1:0]    head_dec;
	logic        [AW-1:0]    rd_addr;
	logic                    we;
	logic        [AW-1:0]    wa;
	logic        [VAL_W-1:0] wd;
	logic                    keep_hit;
	logic        [CW-1:0]    removed;

	// Map a position in the sequence to a slot of the ring
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [SW-1:0] sum;
		sum = SW'(h) + SW'(i);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign full     = (fill_q == CW'(DEPTH));
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign rd_addr  = phys(head_q, idx_q);
	assign keep_hit = rdv_s1 && rdc_s1 && (rdata_s1 != best_q);
	assign removed  = n_q - kept_q;
	assign stat.idx_end = (idx_q == n_q);
	assign res_word = {{(OUT_W - 2 * CNT_W - 1){1'b0}}, occ_q, ovf_q, rcnt_q};

	// Select the single write into the ring
	always_comb begin
		we = 1'b0;
		wa = phys(head_q, kept_q);
		wd = rdata_s1;
		if (cmd.push_front && !full) begin
			we = 1'b1;
			wa = head_dec;
			wd = value;
		end else if (cmd.push_back && !full) begin
			we = 1'b1;
			wa = phys(head_q, fill_q);
			wd = value;
		end else if (keep_hit) begin
			we = 1'b1;
		end
	end

	// Ring storage with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// Advance pointers, counters and the read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			fill_q  <= '0;
			n_q     <= '0;
			idx_q   <= '0;
			kept_q  <= '0;
			first_q <= 1'b0;
			rdv_s1  <= 1'b0;
			rdc_s1  <= 1'b0;
		end else begin
			rdv_s1 <= cmd.rd_scan || cmd.rd_cmp;
			rdc_s1 <= cmd.rd_cmp;
			if (cmd.push_front && !full) begin
				head_q <= head_dec;
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.push_back && !full) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.clear) begin
				fill_q <= '0;
			end
			if (cmd.rm_start) begin
				n_q     <= fill_q;
				idx_q   <= '0;
				kept_q  <= '0;
				first_q <= 1'b1;
			end
			if (cmd.cmp_init) begin
				idx_q <= '0;
			end
			if (cmd.rd_scan || cmd.rd_cmp) begin
				idx_q <= idx_q + CW'(1);
			end
			if (rdv_s1 && !rdc_s1) begin
				first_q <= 1'b0;
			end
			if (keep_hit) begin
				kept_q <= kept_q + CW'(1);
			end
			if (cmd.rm_end) begin
				fill_q <= kept_q;
			end
		end
	end

	// Track the running maximum during the scan pass
	always_ff @(posedge clk) begin
		if (rdv_s1 && !rdc_s1) begin
			if (first_q || (rdata_s1 > best_q)) begin
				best_q <= rdata_s1;
			end
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd.push_front || cmd.push_back) begin
			rcnt_q <= '0;
			ovf_q  <= full;
			occ_q  <= full ? CNT_W'(fill_q) : CNT_W'(fill_q + CW'(1));
		end else if (cmd.clear) begin
			rcnt_q <= '0;
			ovf_q  <= 1'b0;
			occ_q  <= '0;
		end else if (cmd.rm_end) begin
			rcnt_q <= CNT_W'(removed);
			ovf_q  <= 1'b0;
			occ_q  <= CNT_W'(kept_q);
		end
	end

endmodule

[src/deque_remove_all_max_core.sv]
`timescale 1ns / 1ps
// Push front, push back and clear: result word in the cycle after acceptance, one word per
// cycle while m_tready is high. Remove all maxima over n held entries: the ring memory is read
// once per cycle in a max scan pass and then a compaction pass, after which the result is set.
// Reset (arst_n low, asynchronous) empties the store and clears all control state;
// entry contents are undefined until written.

module deque_remove_all_max_core import dram_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] s_tdata,  // [31:0] value
	input  logic [1:0]       s_tuser,  // [1:0] kind
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // [4:0] removed_count, [5] overflow, [10:6] occupancy
);

	dram_cmd_t  cmd;
	dram_stat_t stat;

	dram_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.kind     (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dram_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    ($signed(s_tdata)),
		.cmd      (cmd),
		.stat     (stat),
		.res_word (m_tdata)
	);

`ifndef SYNTHESIS
	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input taken while result word is blocked");

	a_remove_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == KIND_REMOVE)) |=> !s_tready)
		else $error("remove request did not start a pass");

	a_ovf_no_removed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[5] && (m_tdata[4:0] != '0)))
		else $error("overflow reported with removed entries");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((DEPTH > 31) || (m_tdata[10:6] <= 5'(DEPTH))))
		else $error("occupancy beyond capacity");
`endif

endmodule
